/* hdl/deqr_pkg.sv */
// ----------------------------------------------------------------------------
// deqr_pkg
// Shared types and codes for the double-ended queue with remove.
// ----------------------------------------------------------------------------
`default_nettype none

package deqr_pkg;

	localparam int DEPTH_DEF      = 64;
	localparam int WORD_WIDTH_DEF = 32;

	// request function codes
	localparam logic [2:0] FN_PUSH_BACK  = 3'd0;
	localparam logic [2:0] FN_PUSH_FRONT = 3'd1;
	localparam logic [2:0] FN_POP_BACK   = 3'd2;
	localparam logic [2:0] FN_POP_FRONT  = 3'd3;
	localparam logic [2:0] FN_REMOVE     = 3'd4;
	localparam logic [2:0] FN_CLEAR      = 3'd5;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_MISS  = 2'd3;

	typedef struct packed {
		logic [2:0]         func;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [6:0]         count;
		logic signed [31:0] front_value;
		logic signed [31:0] back_value;
	} rsp_t;

	// datapath operations issued by the controller
	typedef enum logic [4:0] {
		DP_NOP,
		DP_LOAD,
		DP_PUSH_BACK,
		DP_PUSH_FRONT,
		DP_POP_BACK,
		DP_POP_FRONT,
		DP_CLEAR,
		DP_IDX_CLR,
		DP_SRCH_RD,
		DP_IDX_INC,
		DP_SHF_RD,
		DP_SHF_WR,
		DP_DEC_COUNT,
		DP_RD_FRONT,
		DP_RD_BACK,
		DP_CAP_BACK,
		DP_LOAD_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] status;
	} dp_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic match;
		logic idx_last;
	} dp_stat_t;

endpackage

`default_nettype wire

/* hdl/double_ended_queue_with_remove.sv */
// ----------------------------------------------------------------------------
// double_ended_queue_with_remove
// Bounded deque of signed words: push/pop at both ends, remove by value, clear.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready, req): one request per transaction,
//   func selects push back/front, pop back/front, remove value or clear.
//   rsp channel (rsp_valid/rsp_ready, rsp): exactly one result per request
//   with status, entry count and the front and back entries (zero if empty).
// Sequencing:
//   One request is in flight at a time. For push, pop and clear, an execute
//   step is followed by reading the front and back entries back through the
//   single read port of the entry RAM (skipped if the queue ends up empty),
//   then the result is loaded and the next request can be accepted. Remove
//   first searches entry by entry from the front (read, compare), and on a
//   match moves each later entry up (read, write) to close the gap, then
//   decrements the count, before the same read-back of front and back.
// Reset:
//   arst_n clears the count and the front pointer; the queue is empty. The
//   entry RAM is not cleared, only written slots are ever read.
// Stalls:
//   The result sits in an output register. The next request is accepted
//   while it waits; that request's result is held back until rsp is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_with_remove import deqr_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencer: owns the handshakes and the status code
	deqr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_func  (req.func),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// storage, pointers, scan index and result register
	deqr_dp #(
		.DEPTH      (DEPTH),
		.WORD_WIDTH (WORD_WIDTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

	// an empty queue reports zero front and back
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.count == 7'd0 |-> rsp.front_value == 32'sd0 &&
			rsp.back_value == 32'sd0)
		else $error("empty result carries nonzero front/back");

	// only one request in flight
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another is in flight");

	// a dropped push is only reported on a full queue
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_FULL |-> rsp.count == 7'(DEPTH))
		else $error("full status with count below depth");

	// loading a result always raises rsp_valid
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == DP_LOAD_OUT |=> rsp_valid)
		else $error("result loaded without rsp_valid");

endmodule

`default_nettype wire

/* hdl/deqr_ram.sv */
// ----------------------------------------------------------------------------
// deqr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module deqr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

/* hdl/deqr_ctrl.sv */
// ----------------------------------------------------------------------------
// deqr_ctrl
// Sequencer: decodes the request and steps the datapath through it.
// ----------------------------------------------------------------------------
`default_nettype none

module deqr_ctrl import deqr_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	input  wire logic [2:0] req_func,
	output logic          req_ready,
	output logic          rsp_valid,
	input  wire logic     rsp_ready,
	output dp_cmd_t       cmd,
	input  wire dp_stat_t stat
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_SHF_RD,
		S_SHF_WR,
		S_RD_FRONT,
		S_RD_BACK,
		S_CAP_BACK,
		S_DONE
	} state_t;

	state_t     state_q, state_d;
	logic [2:0] func_q;
	logic [1:0] status_q, status_d;
	logic       rsp_valid_q;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d    = state_q;
		status_d   = status_q;
		cmd.op     = DP_NOP;
		cmd.status = status_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.op  = DP_LOAD;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				status_d = ST_OK;
				state_d  = S_RD_FRONT;
				case (func_q)
					FN_PUSH_BACK: begin
						if (stat.full) status_d = ST_FULL;
						else cmd.op = DP_PUSH_BACK;
					end
					FN_PUSH_FRONT: begin
						if (stat.full) status_d = ST_FULL;
						else cmd.op = DP_PUSH_FRONT;
					end
					FN_POP_BACK: begin
						if (stat.empty) status_d = ST_EMPTY;
						else cmd.op = DP_POP_BACK;
					end
					FN_POP_FRONT: begin
						if (stat.empty) status_d = ST_EMPTY;
						else cmd.op = DP_POP_FRONT;
					end
					FN_REMOVE: begin
						if (stat.empty) begin
							status_d = ST_EMPTY;
						end else begin
							cmd.op  = DP_IDX_CLR;
							state_d = S_SRCH_RD;
						end
					end
					FN_CLEAR: begin
						cmd.op = DP_CLEAR;
					end
					default: begin
					end
				endcase
			end
			S_SRCH_RD: begin
				cmd.op  = DP_SRCH_RD;
				state_d = S_SRCH_CMP;
			end
			S_SRCH_CMP: begin
				if (stat.match) begin
					state_d = S_SHF_RD;
				end else if (stat.idx_last) begin
					status_d = ST_MISS;
					state_d  = S_RD_FRONT;
				end else begin
					cmd.op  = DP_IDX_INC;
					state_d = S_SRCH_RD;
				end
			end
			S_SHF_RD: begin
				if (stat.idx_last) begin
					cmd.op  = DP_DEC_COUNT;
					state_d = S_RD_FRONT;
				end else begin
					cmd.op  = DP_SHF_RD;
					state_d = S_SHF_WR;
				end
			end
			S_SHF_WR: begin
				cmd.op  = DP_SHF_WR;
				state_d = S_SHF_RD;
			end
			S_RD_FRONT: begin
				if (stat.empty) begin
					state_d = S_DONE;
				end else begin
					cmd.op  = DP_RD_FRONT;
					state_d = S_RD_BACK;
				end
			end
			S_RD_BACK: begin
				cmd.op  = DP_RD_BACK;
				state_d = S_CAP_BACK;
			end
			S_CAP_BACK: begin
				cmd.op  = DP_CAP_BACK;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.op  = DP_LOAD_OUT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			func_q      <= FN_PUSH_BACK;
			status_q    <= ST_OK;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
			if (state_q == S_IDLE && req_valid) begin
				func_q <= req_func;
			end
			if (cmd.op == DP_LOAD_OUT) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/deqr_dp.sv */
// ----------------------------------------------------------------------------
// deqr_dp
// Datapath: circular entry store, front pointer, count, scan index, result.
// ----------------------------------------------------------------------------
`default_nettype none

module deqr_dp import deqr_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire req_t     req,
	input  wire dp_cmd_t  cmd,
	output dp_stat_t      stat,
	output rsp_t          rsp
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = PTR_W + 1;

	logic [WORD_WIDTH-1:0] word_q;
	logic [PTR_W-1:0]      fp_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      idx_q;
	logic [WORD_WIDTH-1:0] front_q;
	logic [WORD_WIDTH-1:0] back_q;
	rsp_t                  rsp_q;

	logic                  wr_en;
	logic [PTR_W-1:0]      wr_addr;
	logic [WORD_WIDTH-1:0] wr_data;
	logic [PTR_W-1:0]      rd_addr;
	logic [WORD_WIDTH-1:0] rd_data;

	logic signed [63:0]    in_ext;
	logic signed [63:0]    front_ext;
	logic signed [63:0]    back_ext;
	logic [CNT_W-1:0]      idx_nxt;
	logic [PTR_W-1:0]      fp_dec;
	logic [PTR_W-1:0]      fp_inc;

	// physical slot of a queue position, base + pos modulo DEPTH
	function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] base,
		input logic [CNT_W-1:0] pos);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(base) + SUM_W'(pos);
		if (sum >= SUM_W'(DEPTH)) begin
			sum = sum - SUM_W'(DEPTH);
		end
		return sum[PTR_W-1:0];
	endfunction

	assign in_ext    = 64'($signed(req.value));
	assign front_ext = 64'($signed(front_q));
	assign back_ext  = 64'($signed(back_q));
	assign idx_nxt   = idx_q + CNT_W'(1);
	assign fp_dec    = (fp_q == '0) ? PTR_W'(DEPTH - 1) : fp_q - PTR_W'(1);
	assign fp_inc    = (fp_q == PTR_W'(DEPTH - 1)) ? '0 : fp_q + PTR_W'(1);

	assign stat.full     = (count_q == CNT_W'(DEPTH));
	assign stat.empty    = (count_q == '0);
	assign stat.match    = (rd_data == word_q);
	assign stat.idx_last = (idx_nxt == count_q);

	assign rsp = rsp_q;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = slot_of(fp_q, count_q);
		wr_data = word_q;
		rd_addr = fp_q;
		case (cmd.op)
			DP_PUSH_BACK: begin
				wr_en = 1'b1;
			end
			DP_PUSH_FRONT: begin
				wr_en   = 1'b1;
				wr_addr = fp_dec;
			end
			DP_SHF_WR: begin
				wr_en   = 1'b1;
				wr_addr = slot_of(fp_q, idx_q);
				wr_data = rd_data;
			end
			DP_SRCH_RD:  rd_addr = slot_of(fp_q, idx_q);
			DP_SHF_RD:   rd_addr = slot_of(fp_q, idx_nxt);
			DP_RD_BACK:  rd_addr = slot_of(fp_q, count_q - CNT_W'(1));
			default: begin
			end
		endcase
	end

	deqr_ram #(
		.WIDTH (WORD_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fp_q    <= '0;
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			case (cmd.op)
				DP_PUSH_BACK: count_q <= count_q + CNT_W'(1);
				DP_PUSH_FRONT: begin
					fp_q    <= fp_dec;
					count_q <= count_q + CNT_W'(1);
				end
				DP_POP_BACK:  count_q <= count_q - CNT_W'(1);
				DP_POP_FRONT: begin
					fp_q    <= fp_inc;
					count_q <= count_q - CNT_W'(1);
				end
				DP_CLEAR: begin
					fp_q    <= '0;
					count_q <= '0;
				end
				DP_DEC_COUNT: count_q <= count_q - CNT_W'(1);
				DP_IDX_CLR:   idx_q   <= '0;
				DP_IDX_INC:   idx_q   <= idx_nxt;
				DP_SHF_WR:    idx_q   <= idx_nxt;
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_LOAD:     word_q  <= in_ext[WORD_WIDTH-1:0];
			DP_RD_BACK:  front_q <= rd_data;
			DP_CAP_BACK: back_q  <= rd_data;
			DP_LOAD_OUT: begin
				rsp_q.status      <= cmd.status;
				rsp_q.count       <= 7'(count_q);
				rsp_q.front_value <= stat.empty ? 32'sd0 : front_ext[31:0];
				rsp_q.back_value  <= stat.empty ? 32'sd0 : back_ext[31:0];
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire
